// ----- sv/mftb_pkg.sv -----
package mftb_pkg;

   localparam int COORD_W   = 32;
   localparam int SUM_W     = 48;
   localparam int AXES      = 3;
   localparam int DIV_NUM_W = 64;
   localparam int DIV_DEN_W = 32;
   localparam int CSR_IDX_W = 3;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [SUM_W-1:0]   sum_type;
   typedef logic [1:0]                axis_type;
   typedef logic [CSR_IDX_W-1:0]      csr_idx_type;

   localparam axis_type AXIS_X = 2'd0;
   localparam axis_type AXIS_Y = 2'd1;
   localparam axis_type AXIS_Z = 2'd2;

   localparam csr_idx_type CSR_BOX_A_X = 3'd0;
   localparam csr_idx_type CSR_BOX_A_Y = 3'd1;
   localparam csr_idx_type CSR_BOX_A_Z = 3'd2;
   localparam csr_idx_type CSR_BOX_B_X = 3'd3;
   localparam csr_idx_type CSR_BOX_B_Y = 3'd4;
   localparam csr_idx_type CSR_BOX_B_Z = 3'd5;

   localparam coord_type COORD_MAX   = 32'sh7FFF_FFFF;
   localparam coord_type COORD_MIN   = 32'sh8000_0000;
   localparam coord_type BOX_A_RESET = -32'sd65536;
   localparam coord_type BOX_B_RESET = 32'sd65536;

   typedef enum logic [1:0] {
      DIV_MEAN_X,
      DIV_MEAN_Y,
      DIV_MEAN_Z,
      DIV_SCALE
   } div_sel_type;

   typedef struct packed {
      logic        gather;
      logic        load_vertex;
      logic        fin_empty;
      logic        div_start;
      div_sel_type start_sel;
      logic        div_store;
      div_sel_type store_sel;
      logic        fin_span_zero;
      logic        mul;
      logic        rnd;
      logic        add;
      logic        push;
      axis_type    axis;
   } dp_cmd_type;

   typedef struct packed {
      logic stats_final;
      logic count_zero;
      logic span_zero;
      logic div_done;
   } dp_status_type;

endpackage

// ----- sv/mftb_req_if.sv -----
interface mftb_req_if import mftb_pkg::*;;
   logic      valid;
   logic      ready;
   logic      func;
   coord_type vertex_x;
   coord_type vertex_y;
   coord_type vertex_z;

   modport source (output valid, func, vertex_x, vertex_y, vertex_z, input ready);
   modport sink (input valid, func, vertex_x, vertex_y, vertex_z, output ready);
endinterface

// ----- sv/mftb_rsp_if.sv -----
interface mftb_rsp_if import mftb_pkg::*;;
   logic      valid;
   logic      ready;
   coord_type out_x;
   coord_type out_y;
   coord_type out_z;
   logic      fit_error;

   modport source (output valid, out_x, out_y, out_z, fit_error, input ready);
   modport sink (input valid, out_x, out_y, out_z, fit_error, output ready);
endinterface

// ----- sv/mftb_csr_if.sv -----
interface mftb_csr_if import mftb_pkg::*;;
   logic        valid;
   logic        ready;
   csr_idx_type index;
   logic [31:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/mftb_div.sv -----
module mftb_div import mftb_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_NUM_W-1:0] num,
   input  logic [DIV_DEN_W-1:0] den,
   output logic                 done,
   output logic [DIV_NUM_W-1:0] quo
);

   localparam int CNT_W = $clog2(DIV_NUM_W);

   logic                 busy_ff;
   logic                 done_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic [DIV_DEN_W-1:0] den_ff;
   logic [DIV_DEN_W-1:0] rem_ff;
   logic [DIV_NUM_W-1:0] rq_ff;
   logic [DIV_DEN_W:0]   shifted;
   logic                 fits;

   assign shifted = {rem_ff, rq_ff[DIV_NUM_W-1]};
   assign fits    = shifted >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(DIV_NUM_W - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         den_ff <= den;
         rem_ff <= '0;
         rq_ff  <= num;
      end else if (busy_ff) begin
         if (fits) begin
            rem_ff <= DIV_DEN_W'(shifted - {1'b0, den_ff});
         end else begin
            rem_ff <= shifted[DIV_DEN_W-1:0];
         end
         rq_ff <= {rq_ff[DIV_NUM_W-2:0], fits};
      end
   end

   assign done = done_ff;
   assign quo  = rq_ff;

endmodule

// ----- sv/mftb_dp.sv -----
module mftb_dp import mftb_pkg::*; #(
   parameter int MAX_VERTICES = 65536,
   parameter int FRAC_BITS    = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_write,
   input  csr_idx_type   csr_index,
   input  logic [31:0]   csr_data,
   input  coord_type     vertex_x,
   input  coord_type     vertex_y,
   input  coord_type     vertex_z,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   output coord_type     out_x,
   output coord_type     out_y,
   output coord_type     out_z,
   output logic          fit_error
);

   localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
   localparam int PROD_W = 2 * COORD_W + 1;
   localparam int MAG_W  = PROD_W + 1;
   localparam int RES_W  = MAG_W + 1;
   localparam logic [CNT_W-1:0]   CNT_MAX    = CNT_W'(MAX_VERTICES);
   localparam logic [31:0]        SCALE_ONE  = 32'(64'd1 << FRAC_BITS);
   localparam logic [MAG_W-1:0]   ROUND_HALF = MAG_W'(1) << (FRAC_BITS - 1);
   localparam logic [DIV_NUM_W-1:0] POS_LIMIT = DIV_NUM_W'(32'h7FFF_FFFF);
   localparam logic [DIV_NUM_W-1:0] NEG_LIMIT = DIV_NUM_W'(32'h8000_0000);

   function automatic coord_type sat_coord(input logic signed [RES_W-1:0] v);
      coord_type r;
      if (v > RES_W'(COORD_MAX)) begin
         r = COORD_MAX;
      end else if (v < RES_W'(COORD_MIN)) begin
         r = COORD_MIN;
      end else begin
         r = v[COORD_W-1:0];
      end
      return r;
   endfunction

   coord_type               box_a_ff [AXES];
   coord_type               box_b_ff [AXES];
   sum_type                 sum_ff [AXES];
   coord_type               low_ff [AXES];
   coord_type               high_ff [AXES];
   coord_type               mean_ff [AXES];
   coord_type               v_ff [AXES];
   coord_type               res_ff [AXES];
   coord_type               out_ff [AXES];
   logic [CNT_W-1:0]        cnt_ff;
   logic [31:0]             scale_ff;
   logic                    final_ff;
   logic                    err_ff;
   logic                    out_err_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic                    neg_ff;
   logic [MAG_W-1:0]        mag_ff;

   coord_type               vin [AXES];
   sum_type                 sum_base [AXES];
   coord_type               low_base [AXES];
   coord_type               high_base [AXES];
   logic [CNT_W-1:0]        cnt_base;
   logic                    gather_ok;
   logic signed [COORD_W:0] span [AXES];
   logic signed [COORD_W:0] center_sum [AXES];
   coord_type               center [AXES];
   axis_type                wide_axis;
   logic signed [COORD_W:0] span_sel;
   logic signed [COORD_W:0] box_diff;
   logic [COORD_W:0]        box_mag;
   sum_type                 mean_sum;
   logic [SUM_W-1:0]        mean_mag;
   logic [DIV_NUM_W-1:0]    div_num;
   logic [DIV_DEN_W-1:0]    div_den;
   logic                    div_done;
   logic [DIV_NUM_W-1:0]    div_quo;
   logic                    store_neg;
   coord_type               mean_q;
   logic [31:0]             scale_q;
   logic signed [COORD_W:0] diff;
   logic signed [PROD_W-1:0] prod_c;
   logic [MAG_W-1:0]        rnd_mag;
   logic [MAG_W-1:0]        shifted_mag;
   logic signed [RES_W-1:0] center_ext;
   logic signed [RES_W-1:0] res_sum;

   assign vin[0] = vertex_x;
   assign vin[1] = vertex_y;
   assign vin[2] = vertex_z;

   always_comb begin
      cnt_base = final_ff ? '0 : cnt_ff;
      for (int i = 0; i < AXES; i++) begin
         sum_base[i]   = final_ff ? '0 : sum_ff[i];
         low_base[i]   = final_ff ? COORD_MAX : low_ff[i];
         high_base[i]  = final_ff ? COORD_MIN : high_ff[i];
         span[i]       = {high_ff[i][COORD_W-1], high_ff[i]} -
                         {low_ff[i][COORD_W-1], low_ff[i]};
         center_sum[i] = {box_a_ff[i][COORD_W-1], box_a_ff[i]} +
                         {box_b_ff[i][COORD_W-1], box_b_ff[i]};
         center[i]     = center_sum[i][COORD_W:1];
      end
   end

   assign gather_ok = cnt_base < CNT_MAX;

   always_comb begin
      if (span[0] > span[1]) begin
         wide_axis = (span[2] > span[0]) ? AXIS_Z : AXIS_X;
      end else begin
         wide_axis = (span[2] > span[1]) ? AXIS_Z : AXIS_Y;
      end
   end

   assign span_sel = span[wide_axis];
   assign box_diff = {box_a_ff[wide_axis][COORD_W-1], box_a_ff[wide_axis]} -
                     {box_b_ff[wide_axis][COORD_W-1], box_b_ff[wide_axis]};
   assign box_mag  = box_diff[COORD_W] ? (COORD_W + 1)'(-box_diff) : box_diff;

   always_comb begin
      case (cmd.start_sel)
         DIV_MEAN_X: mean_sum = sum_ff[0];
         DIV_MEAN_Y: mean_sum = sum_ff[1];
         DIV_MEAN_Z: mean_sum = sum_ff[2];
         default:    mean_sum = sum_ff[0];
      endcase
      mean_mag = mean_sum[SUM_W-1] ? SUM_W'(-mean_sum) : mean_sum;
      if (cmd.start_sel == DIV_SCALE) begin
         div_num = (DIV_NUM_W'(box_mag[COORD_W-1:0]) << FRAC_BITS) +
                   DIV_NUM_W'(span_sel[COORD_W:1]);
         div_den = span_sel[COORD_W-1:0];
      end else begin
         div_num = DIV_NUM_W'(mean_mag) + DIV_NUM_W'(cnt_ff >> 1);
         div_den = DIV_DEN_W'(cnt_ff);
      end
   end

   mftb_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   always_comb begin
      case (cmd.store_sel)
         DIV_MEAN_X: store_neg = sum_ff[0][SUM_W-1];
         DIV_MEAN_Y: store_neg = sum_ff[1][SUM_W-1];
         DIV_MEAN_Z: store_neg = sum_ff[2][SUM_W-1];
         default:    store_neg = 1'b0;
      endcase
      if (store_neg) begin
         mean_q = (div_quo > NEG_LIMIT) ? COORD_MIN : -coord_type'(div_quo[COORD_W-1:0]);
      end else begin
         mean_q = (div_quo > POS_LIMIT) ? COORD_MAX : div_quo[COORD_W-1:0];
      end
      scale_q = (div_quo > POS_LIMIT) ? 32'h7FFF_FFFF : div_quo[31:0];
   end

   assign diff        = {v_ff[cmd.axis][COORD_W-1], v_ff[cmd.axis]} -
                        {mean_ff[cmd.axis][COORD_W-1], mean_ff[cmd.axis]};
   assign prod_c      = diff * $signed(scale_ff);
   assign rnd_mag     = prod_ff[PROD_W-1] ? ROUND_HALF - MAG_W'(prod_ff)
                                           : MAG_W'(prod_ff) + ROUND_HALF;
   assign shifted_mag = mag_ff >> FRAC_BITS;
   assign center_ext  = RES_W'(center[cmd.axis]);
   assign res_sum     = neg_ff ? center_ext - $signed({1'b0, shifted_mag})
                               : center_ext + $signed({1'b0, shifted_mag});

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < AXES; i++) begin
            box_a_ff[i] <= BOX_A_RESET;
            box_b_ff[i] <= BOX_B_RESET;
            sum_ff[i]   <= '0;
            low_ff[i]   <= COORD_MAX;
            high_ff[i]  <= COORD_MIN;
            mean_ff[i]  <= '0;
         end
         cnt_ff   <= '0;
         scale_ff <= SCALE_ONE;
         final_ff <= 1'b0;
         err_ff   <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_BOX_A_X: box_a_ff[0] <= csr_data;
               CSR_BOX_A_Y: box_a_ff[1] <= csr_data;
               CSR_BOX_A_Z: box_a_ff[2] <= csr_data;
               CSR_BOX_B_X: box_b_ff[0] <= csr_data;
               CSR_BOX_B_Y: box_b_ff[1] <= csr_data;
               CSR_BOX_B_Z: box_b_ff[2] <= csr_data;
               default: ;
            endcase
         end
         if (cmd.gather) begin
            final_ff <= 1'b0;
            err_ff   <= 1'b0;
            cnt_ff   <= gather_ok ? cnt_base + 1'b1 : cnt_base;
            for (int i = 0; i < AXES; i++) begin
               if (gather_ok) begin
                  sum_ff[i]  <= sum_base[i] + {{(SUM_W - COORD_W){vin[i][COORD_W-1]}}, vin[i]};
                  low_ff[i]  <= (vin[i] < low_base[i]) ? vin[i] : low_base[i];
                  high_ff[i] <= (vin[i] > high_base[i]) ? vin[i] : high_base[i];
               end else begin
                  sum_ff[i]  <= sum_base[i];
                  low_ff[i]  <= low_base[i];
                  high_ff[i] <= high_base[i];
               end
            end
         end
         if (cmd.fin_empty) begin
            for (int i = 0; i < AXES; i++) begin
               mean_ff[i] <= '0;
            end
            scale_ff <= SCALE_ONE;
            err_ff   <= 1'b1;
            final_ff <= 1'b1;
         end
         if (cmd.fin_span_zero) begin
            scale_ff <= SCALE_ONE;
            err_ff   <= 1'b1;
            final_ff <= 1'b1;
         end
         if (cmd.div_store) begin
            case (cmd.store_sel)
               DIV_MEAN_X: mean_ff[0] <= mean_q;
               DIV_MEAN_Y: mean_ff[1] <= mean_q;
               DIV_MEAN_Z: mean_ff[2] <= mean_q;
               default: begin
                  scale_ff <= scale_q;
                  final_ff <= 1'b1;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_vertex) begin
         for (int i = 0; i < AXES; i++) begin
            v_ff[i] <= vin[i];
         end
      end
      if (cmd.mul) begin
         prod_ff <= prod_c;
      end
      if (cmd.rnd) begin
         neg_ff <= prod_ff[PROD_W-1];
         mag_ff <= rnd_mag;
      end
      if (cmd.add) begin
         res_ff[cmd.axis] <= sat_coord(res_sum);
      end
      if (cmd.push) begin
         for (int i = 0; i < AXES; i++) begin
            out_ff[i] <= res_ff[i];
         end
         out_err_ff <= err_ff;
      end
   end

   assign status.stats_final = final_ff;
   assign status.count_zero  = cnt_ff == '0;
   assign status.span_zero   = span_sel[COORD_W] || (span_sel == '0);
   assign status.div_done    = div_done;

   assign out_x     = out_ff[0];
   assign out_y     = out_ff[1];
   assign out_z     = out_ff[2];
   assign fit_error = out_err_ff;

endmodule

// ----- sv/mftb_ctrl.sv -----
module mftb_ctrl import mftb_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_func,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIN,
      ST_DIV,
      ST_MUL,
      ST_RND,
      ST_ADD,
      ST_PUSH
   } state_type;

   state_type   state_ff, state_in;
   axis_type    axis_ff, axis_in;
   div_sel_type sel_ff, sel_in;
   logic        rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd           = '0;
      cmd.axis      = axis_ff;
      cmd.start_sel = sel_ff;
      cmd.store_sel = sel_ff;
      state_in      = state_ff;
      axis_in       = axis_ff;
      sel_in        = sel_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (!req_func) begin
                  cmd.gather = 1'b1;
               end else begin
                  cmd.load_vertex = 1'b1;
                  axis_in         = AXIS_X;
                  state_in        = status.stats_final ? ST_MUL : ST_FIN;
               end
            end
         end
         ST_FIN: begin
            if (status.count_zero) begin
               cmd.fin_empty = 1'b1;
               state_in      = ST_MUL;
            end else begin
               cmd.div_start = 1'b1;
               cmd.start_sel = DIV_MEAN_X;
               sel_in        = DIV_MEAN_X;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            if (status.div_done) begin
               cmd.div_store = 1'b1;
               case (sel_ff)
                  DIV_MEAN_X: begin
                     cmd.div_start = 1'b1;
                     cmd.start_sel = DIV_MEAN_Y;
                     sel_in        = DIV_MEAN_Y;
                  end
                  DIV_MEAN_Y: begin
                     cmd.div_start = 1'b1;
                     cmd.start_sel = DIV_MEAN_Z;
                     sel_in        = DIV_MEAN_Z;
                  end
                  DIV_MEAN_Z: begin
                     if (status.span_zero) begin
                        cmd.fin_span_zero = 1'b1;
                        state_in          = ST_MUL;
                     end else begin
                        cmd.div_start = 1'b1;
                        cmd.start_sel = DIV_SCALE;
                        sel_in        = DIV_SCALE;
                     end
                  end
                  default: begin
                     state_in = ST_MUL;
                  end
               endcase
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_RND;
         end
         ST_RND: begin
            cmd.rnd  = 1'b1;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            cmd.add = 1'b1;
            if (axis_ff == AXIS_Z) begin
               state_in = ST_PUSH;
            end else begin
               axis_in  = axis_ff + 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_PUSH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.push     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         axis_ff      <= AXIS_X;
         sel_ff       <= DIV_MEAN_X;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

   // A new result may only be loaded into a free or draining output register.
   a_push_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over a pending one");

   a_store_on_done: assert property (@(posedge clock) disable iff (reset)
      cmd.div_store |-> status.div_done)
      else $error("quotient stored before the divider finished");

   a_stats_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |-> status.stats_final)
      else $error("transform started before statistics finished");

   a_valid_from_push: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.push))
      else $error("response raised without a result");

endmodule

// ----- sv/mesh_fit_to_box.sv -----
// Two-pass vertex normalizer. A gather request (func 0) returns nothing and
// leaves the block ready for the next request. A transform request (func 1)
// returns one response, working one axis at a time through a shared multiply,
// round and offset stage; the next request is taken once the result has been
// pushed into the response register, which waits while that register still
// holds an unaccepted response. The first transform after reset or a gather
// also finishes the mesh statistics: for a non-empty mesh, three mean
// divisions and, unless the widest span is zero, one scale division run on
// a shared 64-step radix-2 divider. Register writes are always accepted.
module mesh_fit_to_box import mftb_pkg::*; #(
   parameter int MAX_VERTICES = 65536,
   parameter int FRAC_BITS    = 16
) (
   input  logic       clock,
   input  logic       reset,
   mftb_req_if.sink   req_bus,
   mftb_rsp_if.source rsp_bus,
   mftb_csr_if.sink   csr_bus
);

   dp_cmd_type    cmd;
   dp_status_type status;
   logic          req_ready;
   logic          rsp_valid;

   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = req_ready;
   assign rsp_bus.valid = rsp_valid;

   mftb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_func  (req_bus.func),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   mftb_dp #(
      .MAX_VERTICES (MAX_VERTICES),
      .FRAC_BITS    (FRAC_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_bus.valid),
      .csr_index (csr_bus.index),
      .csr_data  (csr_bus.data),
      .vertex_x  (req_bus.vertex_x),
      .vertex_y  (req_bus.vertex_y),
      .vertex_z  (req_bus.vertex_z),
      .cmd       (cmd),
      .status    (status),
      .out_x     (rsp_bus.out_x),
      .out_y     (rsp_bus.out_y),
      .out_z     (rsp_bus.out_z),
      .fit_error (rsp_bus.fit_error)
   );

endmodule

// ----- tb/sv/mesh_fit_check.sv -----
module mesh_fit_check import mftb_pkg::*; (
   input  logic clock,
   input  logic reset,
   mftb_req_if  req_bus,
   mftb_rsp_if  rsp_bus,
   mftb_csr_if  csr_bus,
   output int   fail_count,
   output int   pending,
   output int   gathered,
   output int   ignored,
   output int   placed,
   output int   flagged
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int        FRAC         = 16;
   localparam int        MAX_VERTICES = 65536;
   localparam logic      FUNC_PLACE   = 1'b1;
   localparam coord_type ONE_Q        = 32'sd65536;
   localparam int        PRINT_LIMIT  = 30;

   typedef struct packed {
      coord_type out_x;
      coord_type out_y;
      coord_type out_z;
      logic      fit_error;
   } placed_fit_t;

   placed_fit_t fit_queue[$];
   int          responses;

   coord_type   corner_a[AXES];
   coord_type   corner_b[AXES];
   sum_type     acc[AXES];
   int unsigned n_vertices;
   coord_type   mesh_min[AXES];
   coord_type   mesh_max[AXES];
   coord_type   centroid[AXES];
   coord_type   scale;
   bit          stats_done;
   bit          fit_bad;

   function automatic coord_type clamp32(longint v);
      if (v > longint'(COORD_MAX)) return COORD_MAX;
      if (v < longint'(COORD_MIN)) return COORD_MIN;
      return coord_type'(v);
   endfunction

   function automatic void restart_mesh();
      for (int i = 0; i < AXES; i++) begin
         acc[i] = '0;
         mesh_min[i] = COORD_MAX;
         mesh_max[i] = COORD_MIN;
      end
      n_vertices = 0;
      stats_done = 1'b0;
      fit_bad = 1'b0;
   endfunction

   function automatic coord_type rounded_mean(sum_type s, int unsigned n);
      longint            sv;
      longint unsigned   mag;
      longint unsigned   q;
      sv = longint'(s);
      mag = (sv < 0) ? -sv : sv;
      q = (mag + n / 2) / n;
      return clamp32((sv < 0) ? -longint'(q) : longint'(q));
   endfunction

   function automatic void finish_stats();
      longint          span[AXES];
      longint unsigned box_span;
      longint unsigned d;
      longint unsigned q;
      axis_type        ax;
      stats_done = 1'b1;
      scale = ONE_Q;
      if (n_vertices == 0) begin
         for (int i = 0; i < AXES; i++) centroid[i] = '0;
         fit_bad = 1'b1;
         return;
      end
      for (int i = 0; i < AXES; i++) begin
         centroid[i] = rounded_mean(acc[i], n_vertices);
         span[i] = longint'(mesh_max[i]) - longint'(mesh_min[i]);
      end
      if (span[AXIS_X] > span[AXIS_Y]) ax = (span[AXIS_Z] > span[AXIS_X]) ? AXIS_Z : AXIS_X;
      else ax = (span[AXIS_Z] > span[AXIS_Y]) ? AXIS_Z : AXIS_Y;
      if (span[ax] <= 0) begin
         fit_bad = 1'b1;
         return;
      end
      d = longint'(corner_a[ax]) - longint'(corner_b[ax]);
      box_span = (longint'(d) < 0) ? -longint'(d) : d;
      d = span[ax];
      q = ((box_span << FRAC) + d / 2) / d;
      scale = (q > 64'h7FFF_FFFF) ? COORD_MAX : coord_type'(q[31:0]);
   endfunction

   function automatic coord_type box_center(coord_type a, coord_type b);
      longint s;
      s = longint'(a) + longint'(b);
      return coord_type'((s - (s & 64'sd1)) / 2);
   endfunction

   function automatic coord_type map_axis(coord_type v, coord_type mu, coord_type ctr);
      longint          d;
      longint          p;
      longint          q;
      longint unsigned mag;
      longint unsigned r;
      d = longint'(v) - longint'(mu);
      p = d * longint'(scale);
      mag = (p < 0) ? -p : p;
      r = (mag + (64'd1 << (FRAC - 1))) >> FRAC;
      q = (p < 0) ? -longint'(r) : longint'(r);
      return clamp32(q + longint'(ctr));
   endfunction

   function automatic void gather_vertex(coord_type x, coord_type y, coord_type z);
      coord_type v[AXES];
      v[AXIS_X] = x;
      v[AXIS_Y] = y;
      v[AXIS_Z] = z;
      if (stats_done) restart_mesh();
      if (n_vertices >= MAX_VERTICES) begin
         ignored++;
         return;
      end
      n_vertices++;
      for (int i = 0; i < AXES; i++) begin
         acc[i] = acc[i] + sum_type'(v[i]);
         if (v[i] < mesh_min[i]) mesh_min[i] = v[i];
         if (v[i] > mesh_max[i]) mesh_max[i] = v[i];
      end
   endfunction

   function automatic placed_fit_t place_vertex(coord_type x, coord_type y, coord_type z);
      placed_fit_t fit;
      if (!stats_done) finish_stats();
      fit.out_x = map_axis(x, centroid[AXIS_X], box_center(corner_a[AXIS_X], corner_b[AXIS_X]));
      fit.out_y = map_axis(y, centroid[AXIS_Y], box_center(corner_a[AXIS_Y], corner_b[AXIS_Y]));
      fit.out_z = map_axis(z, centroid[AXIS_Z], box_center(corner_a[AXIS_Z], corner_b[AXIS_Z]));
      fit.fit_error = fit_bad;
      return fit;
   endfunction

   function automatic void write_box(csr_idx_type idx, coord_type value);
      case (idx)
         CSR_BOX_A_X: corner_a[AXIS_X] = value;
         CSR_BOX_A_Y: corner_a[AXIS_Y] = value;
         CSR_BOX_A_Z: corner_a[AXIS_Z] = value;
         CSR_BOX_B_X: corner_b[AXIS_X] = value;
         CSR_BOX_B_Y: corner_b[AXIS_Y] = value;
         CSR_BOX_B_Z: corner_b[AXIS_Z] = value;
         default: ;
      endcase
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      fail_count++;
      if (fail_count <= PRINT_LIMIT)
         $display("%0t: response %0d, %s is %0d, expected %0d", $time, responses, field, got, want);
   endtask

   task automatic compare_fit();
      placed_fit_t want;
      responses++;
      if (fit_queue.size() == 0) begin
         report_mismatch("unrequested response, out_x", rsp_bus.out_x, 0);
         return;
      end
      want = fit_queue.pop_front();
      if (want.fit_error) flagged++;
      if (rsp_bus.out_x !== want.out_x) report_mismatch("out_x", rsp_bus.out_x, want.out_x);
      if (rsp_bus.out_y !== want.out_y) report_mismatch("out_y", rsp_bus.out_y, want.out_y);
      if (rsp_bus.out_z !== want.out_z) report_mismatch("out_z", rsp_bus.out_z, want.out_z);
      if (rsp_bus.fit_error !== want.fit_error)
         report_mismatch("fit_error", rsp_bus.fit_error, want.fit_error);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < AXES; i++) begin
            corner_a[i] = BOX_A_RESET;
            corner_b[i] = BOX_B_RESET;
            centroid[i] = '0;
         end
         restart_mesh();
         scale = ONE_Q;
         fit_queue.delete();
         fail_count = 0;
         responses = 0;
         gathered = 0;
         ignored = 0;
         placed = 0;
         flagged = 0;
      end else begin
         if (csr_bus.valid && csr_bus.ready) write_box(csr_bus.index, csr_bus.data);
         if (rsp_bus.valid && rsp_bus.ready) compare_fit();
         if (req_bus.valid && req_bus.ready) begin
            if (req_bus.func == FUNC_PLACE) begin
               fit_queue.push_back(place_vertex(req_bus.vertex_x, req_bus.vertex_y,
                                                req_bus.vertex_z));
               placed++;
            end else begin
               gather_vertex(req_bus.vertex_x, req_bus.vertex_y, req_bus.vertex_z);
               gathered++;
            end
         end
      end
      pending = fit_queue.size();
   end
endmodule

// ----- tb/sv/tb.sv -----
module tb import mftb_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic        FUNC_GATHER   = 1'b0;
   localparam logic        FUNC_PLACE    = 1'b1;
   localparam csr_idx_type CSR_SPARE_LO  = 3'd6;
   localparam csr_idx_type CSR_SPARE_HI  = 3'd7;
   localparam int          RANDOM_ITEMS  = 950;
   localparam int          MESH_LIMIT    = 65536;
   localparam int          SETTLE_CYCLES = 16;
   localparam int          HOLD_CYCLES   = 300;
   localparam int          IDLE_LIMIT    = 4000;

   typedef enum {SHAPE_SCATTER, SHAPE_POINT, SHAPE_AXES, SHAPE_CLUSTER} mesh_shape_t;
   typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_RHYTHM} rx_mode_t;

   logic clock;
   logic reset;

   mftb_req_if req_bus ();
   mftb_rsp_if rsp_bus ();
   mftb_csr_if csr_bus ();

   int fail_count;
   int pending;
   int gathered;
   int ignored;
   int placed;
   int flagged;
   int idle_cycles;
   int items_sent;
   int csr_writes;
   int sessions;
   int burst_left;
   bit steady;
   bit hold_request;

   mesh_fit_to_box dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   mesh_fit_check fit_check (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .rsp_bus    (rsp_bus),
      .csr_bus    (csr_bus),
      .fail_count (fail_count),
      .pending    (pending),
      .gathered   (gathered),
      .ignored    (ignored),
      .placed     (placed),
      .flagged    (flagged)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic coord_type small_coord();
      return coord_type'($urandom_range(0, 32'h001F_FFFF)) - 32'sh0010_0000;
   endfunction

   function automatic coord_type rand_coord();
      case ($urandom_range(0, 7))
         0: return COORD_MAX;
         1: return COORD_MIN;
         2: return '0;
         3, 4: return small_coord();
         default: return coord_type'($urandom);
      endcase
   endfunction

   function automatic coord_type rand_box_value();
      case ($urandom_range(0, 7))
         0: return COORD_MAX;
         1: return COORD_MIN;
         2: return BOX_A_RESET;
         3: return BOX_B_RESET;
         4, 5: return small_coord();
         default: return coord_type'($urandom);
      endcase
   endfunction

   task automatic send_req(input logic f, input coord_type x, input coord_type y,
                           input coord_type z);
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 16);
         if (!steady && $urandom_range(0, 2) != 0) begin
            req_bus.valid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clock);
         end
      end
      burst_left--;
      req_bus.valid = 1'b1;
      req_bus.func = f;
      req_bus.vertex_x = x;
      req_bus.vertex_y = y;
      req_bus.vertex_z = z;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic write_reg(input csr_idx_type idx, input coord_type value);
      csr_bus.valid = 1'b1;
      csr_bus.index = idx;
      csr_bus.data = value;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid = 1'b0;
      csr_writes++;
   endtask

   task automatic set_box(input coord_type ax, input coord_type ay, input coord_type az,
                          input coord_type bx, input coord_type by, input coord_type bz);
      write_reg(CSR_BOX_A_X, ax);
      write_reg(CSR_BOX_A_Y, ay);
      write_reg(CSR_BOX_A_Z, az);
      write_reg(CSR_BOX_B_X, bx);
      write_reg(CSR_BOX_B_Y, by);
      write_reg(CSR_BOX_B_Z, bz);
   endtask

   // A gather leaves no response behind, so give the block time to finish one.
   task automatic drain();
      req_bus.valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic mesh_session(input mesh_shape_t shape, input int n_gather, input int n_place);
      coord_type      base[AXES];
      coord_type      pt[AXES];
      coord_type      shared;
      logic [AXES-1:0] tied;
      int unsigned    spread;
      for (int i = 0; i < AXES; i++) base[i] = small_coord();
      tied = $urandom_range(1, 7);
      spread = 1 << $urandom_range(0, 20);
      sessions++;
      for (int g = 0; g < n_gather; g++) begin
         shared = coord_type'($urandom_range(0, spread));
         for (int i = 0; i < AXES; i++) begin
            case (shape)
               SHAPE_SCATTER: pt[i] = rand_coord();
               SHAPE_POINT:   pt[i] = base[i];
               SHAPE_AXES:    pt[i] = tied[i] ? base[i] + shared : base[i];
               default:       pt[i] = base[i] + coord_type'($urandom_range(0, spread));
            endcase
         end
         send_req(FUNC_GATHER, pt[AXIS_X], pt[AXIS_Y], pt[AXIS_Z]);
      end
      for (int p = 0; p < n_place; p++) begin
         for (int i = 0; i < AXES; i++)
            pt[i] = $urandom_range(0, 1) ? rand_coord()
                                         : base[i] + coord_type'($urandom_range(0, spread));
         send_req(FUNC_PLACE, pt[AXIS_X], pt[AXIS_Y], pt[AXIS_Z]);
      end
   endtask

   task automatic noise(input int n);
      for (int k = 0; k < n; k++)
         send_req($urandom_range(0, 1) ? FUNC_PLACE : FUNC_GATHER, rand_coord(), rand_coord(),
                  rand_coord());
   endtask

   initial begin : rsp_side
      rx_mode_t mode;
      int       left;
      rsp_bus.ready = 1'b0;
      mode = RX_OPEN;
      left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_bus.ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            continue;
         end
         if (left == 0) begin
            mode = rx_mode_t'($urandom_range(0, 3));
            left = $urandom_range(8, 80);
         end
         left--;
         case (mode)
            RX_OPEN:   rsp_bus.ready = 1'b1;
            RX_COIN:   rsp_bus.ready = $urandom_range(0, 1);
            RX_SPARSE: rsp_bus.ready = ($urandom_range(0, 4) == 0);
            default:   rsp_bus.ready = (left % 3 != 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("No request or response moved for %0d cycles.", IDLE_LIMIT);
         $display("mesh_fit_to_box test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      int start;
      int iter;
      reset = 1'b1;
      idle_cycles = 0;
      items_sent = 0;
      csr_writes = 0;
      sessions = 0;
      burst_left = 0;
      steady = 1'b0;
      hold_request = 1'b0;
      req_bus.valid = 1'b0;
      req_bus.func = FUNC_GATHER;
      req_bus.vertex_x = '0;
      req_bus.vertex_y = '0;
      req_bus.vertex_z = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_BOX_A_X;
      csr_bus.data = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Transforms with no vertex gathered, then a one-vertex mesh, then a three-vertex one.
      send_req(FUNC_PLACE, COORD_MAX, COORD_MIN, '0);
      send_req(FUNC_PLACE, COORD_MIN, COORD_MAX, -1);
      send_req(FUNC_GATHER, 123456, -7, COORD_MAX);
      send_req(FUNC_PLACE, 123456, '0, COORD_MIN);
      send_req(FUNC_GATHER, COORD_MAX, COORD_MIN, '0);
      send_req(FUNC_GATHER, COORD_MIN, COORD_MAX, 1);
      send_req(FUNC_GATHER, '0, '0, -1);
      send_req(FUNC_PLACE, COORD_MAX, COORD_MIN, COORD_MAX);
      send_req(FUNC_PLACE, '0, '0, '0);
      drain();

      // Widest possible box on a unit-span mesh saturates the scale; flat box in y.
      set_box(COORD_MIN, 5, 32'sh0001_0000, COORD_MAX, 5, -32'sh0003_0000);
      write_reg(CSR_SPARE_LO, '0);
      write_reg(CSR_SPARE_HI, COORD_MAX);
      send_req(FUNC_GATHER, '0, '0, '0);
      send_req(FUNC_GATHER, 1, '0, '0);
      send_req(FUNC_PLACE, COORD_MAX, COORD_MIN, 3);
      send_req(FUNC_PLACE, -1, 1, '0);
      drain();

      // New box while the statistics stay latched, then ties between spans.
      set_box(32'sh0004_0000, BOX_B_RESET, COORD_MIN, -32'sh0004_0000, BOX_A_RESET, COORD_MIN);
      send_req(FUNC_PLACE, 1, 2, 3);
      send_req(FUNC_PLACE, COORD_MAX, COORD_MAX, COORD_MAX);
      send_req(FUNC_GATHER, '0, '0, '0);
      send_req(FUNC_GATHER, 65536, 65536, 65536);
      send_req(FUNC_PLACE, 32768, 32768, 32768);
      send_req(FUNC_PLACE, COORD_MIN, COORD_MIN, COORD_MIN);
      send_req(FUNC_GATHER, '0, '0, '0);
      send_req(FUNC_GATHER, 4, 4, 1);
      send_req(FUNC_PLACE, 2, 2, 2);
      drain();

      // Gather up to the vertex limit; the extra vertices must be dropped.
      set_box(BOX_A_RESET, BOX_A_RESET, BOX_A_RESET, BOX_B_RESET, BOX_B_RESET, BOX_B_RESET);
      steady = 1'b1;
      for (int k = 0; k < MESH_LIMIT; k++)
         send_req(FUNC_GATHER, rand_coord(), rand_coord(), rand_coord());
      send_req(FUNC_GATHER, COORD_MAX, COORD_MAX, COORD_MAX);
      send_req(FUNC_GATHER, COORD_MIN, COORD_MIN, COORD_MIN);
      for (int k = 0; k < 4; k++)
         send_req(FUNC_GATHER, rand_coord(), rand_coord(), rand_coord());
      for (int k = 0; k < 4; k++)
         send_req(FUNC_PLACE, rand_coord(), rand_coord(), rand_coord());
      steady = 1'b0;
      drain();

      start = items_sent;
      iter = 0;
      while (items_sent - start < RANDOM_ITEMS) begin
         if (iter == 4) begin
            // Hold the response side off while transforms keep coming.
            hold_request = 1'b1;
            for (int k = 0; k < 40; k++)
               send_req(FUNC_PLACE, rand_coord(), rand_coord(), rand_coord());
            drain();
         end
         if ($urandom_range(0, 5) == 0) begin
            drain();
            set_box(rand_box_value(), rand_box_value(), rand_box_value(),
                    rand_box_value(), rand_box_value(), rand_box_value());
            if ($urandom_range(0, 3) == 0)
               write_reg($urandom_range(0, 1) ? CSR_SPARE_LO : CSR_SPARE_HI, rand_coord());
         end
         if ($urandom_range(0, 4) == 0)
            noise($urandom_range(1, 10));
         else
            mesh_session(mesh_shape_t'($urandom_range(0, 3)),
                         ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12),
                         $urandom_range(0, 6));
         iter++;
      end
      drain();

      $display("Covered %0d gathers (%0d past the vertex limit) and %0d transforms,",
               gathered, ignored, placed);
      $display("%0d of them flagged, over %0d mesh sessions and %0d register writes.",
               flagged, sessions, csr_writes);
      if (fail_count == 0 && pending == 0) begin
         $display("mesh_fit_to_box test passed");
      end else begin
         $display("mesh_fit_to_box test failed");
      end
      $finish;
   end
endmodule

// ----- sim.f -----
sv/mftb_pkg.sv
sv/mftb_req_if.sv
sv/mftb_rsp_if.sv
sv/mftb_csr_if.sv
sv/mftb_div.sv
sv/mftb_dp.sv
sv/mftb_ctrl.sv
sv/mesh_fit_to_box.sv
tb/sv/mesh_fit_check.sv
tb/sv/tb.sv
